// File: rtl/cvg_pkg.sv
// ----------------------------------------------------------------------------
// cvg_pkg
// Shared types, codes, threshold lists and the chord table for the chord
// voicing generator.
// ----------------------------------------------------------------------------
package cvg_pkg;

  localparam int HystWidth  = 9;
  localparam int CodeWidth  = 3;
  localparam int ThrWidth   = 13;
  localparam int MaxThr     = 7;

  localparam logic [HystWidth-1:0] HystReset = 9'd150;

  // configuration register indexes
  localparam logic [1:0] REG_QUALITY_HYST   = 2'd0;
  localparam logic [1:0] REG_VARIATION_HYST = 2'd1;
  localparam logic [1:0] REG_VOICING_HYST   = 2'd2;

  // chord qualities
  localparam logic [2:0] QUAL_MAJ = 3'd0;
  localparam logic [2:0] QUAL_MIN = 3'd1;
  localparam logic [2:0] QUAL_DOM = 3'd2;
  localparam logic [2:0] QUAL_DIM = 3'd3;
  localparam logic [2:0] QUAL_SUS = 3'd4;
  localparam logic [2:0] QUAL_AUG = 3'd5;

  // voicings
  localparam logic [2:0] VOIC_ROOT    = 3'd0;
  localparam logic [2:0] VOIC_FIRST   = 3'd1;
  localparam logic [2:0] VOIC_SECOND  = 3'd2;
  localparam logic [2:0] VOIC_THIRD   = 3'd3;
  localparam logic [2:0] VOIC_DROP2   = 3'd4;
  localparam logic [2:0] VOIC_DROP3   = 3'd5;
  localparam logic [2:0] VOIC_SPREAD  = 3'd6;
  localparam logic [2:0] VOIC_SPREAD2 = 3'd7;

  typedef logic [MaxThr-1:0][ThrWidth-1:0] thr_list_t;

  // entry 0 is the lowest threshold; unused upper entries are zero
  localparam thr_list_t QualityThr = {13'd0, 13'd0, 13'd4100, 13'd3280,
                                      13'd2460, 13'd1640, 13'd820};
  localparam thr_list_t VarMajMinThr = {13'd0, 13'd0, 13'd0, 13'd0,
                                        13'd3072, 13'd2048, 13'd1024};
  localparam thr_list_t VarDimAugThr = {13'd0, 13'd0, 13'd0, 13'd0,
                                        13'd0, 13'd2730, 13'd1365};
  localparam thr_list_t VarSusThr = {13'd0, 13'd0, 13'd0, 13'd0,
                                     13'd0, 13'd0, 13'd2048};
  localparam thr_list_t VoicingThr = {13'd3584, 13'd3072, 13'd2560, 13'd2048,
                                      13'd1536, 13'd1024, 13'd512};

  typedef struct packed {
    logic [HystWidth-1:0] quality;
    logic [HystWidth-1:0] variation;
    logic [HystWidth-1:0] voicing;
  } hyst_t;

  typedef struct packed {
    logic [CodeWidth-1:0] quality;
    logic [1:0]           variation;
    logic [CodeWidth-1:0] voicing;
  } codes_t;

  typedef logic [2:0][3:0] semis_t;

  // Hysteresis quantizer: thresholds tested from the highest down.
  function automatic logic [CodeWidth-1:0] quantize(
    input logic [15:0]           p,
    input thr_list_t             thr,
    input logic [2:0]            n,
    input logic [HystWidth-1:0]  h,
    input logic [CodeWidth-1:0]  prev
  );
    logic [CodeWidth-1:0] code;
    logic                 done;
    logic [16:0]          hi;
    logic [16:0]          lo;
    code = '0;
    done = 1'b0;
    hi   = '0;
    lo   = '0;
    for (int i = MaxThr - 1; i >= 0; i--) begin
      hi = 17'(thr[i]) + 17'(h);
      lo = 17'(thr[i]) - 17'(h);
      if (!done && (i < int'(n))) begin
        if ({1'b0, p} > hi) begin
          code = CodeWidth'(i + 1);
          done = 1'b1;
        end else if ({1'b0, p} > lo) begin
          code = prev;
          done = 1'b1;
        end
      end
    end
    return code;
  endfunction

  // chord tones in semitones above the root, tone 0 in the low nibble
  function automatic semis_t chord_semis(input logic [2:0] q, input logic [1:0] v);
    semis_t s;
    s = {4'd12, 4'd7, 4'd4};
    case (q)
      QUAL_MAJ: begin
        case (v)
          2'd0:    s = {4'd12, 4'd7, 4'd4};
          2'd1:    s = {4'd11, 4'd7, 4'd4};
          2'd2:    s = {4'd9,  4'd7, 4'd4};
          default: s = {4'd10, 4'd6, 4'd4};
        endcase
      end
      QUAL_MIN: begin
        case (v)
          2'd0:    s = {4'd12, 4'd7, 4'd3};
          2'd1:    s = {4'd10, 4'd7, 4'd3};
          2'd2:    s = {4'd9,  4'd7, 4'd3};
          default: s = {4'd11, 4'd7, 4'd3};
        endcase
      end
      QUAL_DOM: s = {4'd10, 4'd7, 4'd4};
      QUAL_DIM: begin
        case (v)
          2'd0:    s = {4'd12, 4'd6, 4'd3};
          2'd1:    s = {4'd9,  4'd6, 4'd3};
          default: s = {4'd10, 4'd6, 4'd3};
        endcase
      end
      QUAL_SUS: begin
        case (v)
          2'd0:    s = {4'd12, 4'd7, 4'd2};
          default: s = {4'd12, 4'd7, 4'd5};
        endcase
      end
      QUAL_AUG: begin
        case (v)
          2'd0:    s = {4'd12, 4'd8, 4'd4};
          2'd1:    s = {4'd10, 4'd8, 4'd4};
          default: s = {4'd9,  4'd7, 4'd4};
        endcase
      end
      default: s = {4'd12, 4'd7, 4'd4};
    endcase
    return s;
  endfunction

endpackage

// File: rtl/cvg_quantizer_bank.sv
// ----------------------------------------------------------------------------
// cvg_quantizer_bank
// Hysteresis quantizers for quality, variation and voicing with their
// code memories; memories load when a word moves to the result register.
// ----------------------------------------------------------------------------
module cvg_quantizer_bank (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [15:0]    quality_knob,
  input  logic [15:0]    variation_knob,
  input  logic [15:0]    voicing_knob,
  input  cvg_pkg::hyst_t hyst,
  output cvg_pkg::codes_t codes
);
  import cvg_pkg::*;

  logic [2:0] last_quality;
  logic [1:0] last_variation_major_minor;
  logic [1:0] last_variation_dim_aug;
  logic       last_variation_sus;
  logic [2:0] last_voicing;

  logic [15:0] qp;
  logic [15:0] vp;
  logic [2:0]  quality_next;
  logic [2:0]  var_mm;
  logic [2:0]  var_da;
  logic [2:0]  var_sus;
  logic [2:0]  voicing_next;
  logic [1:0]  variation_sel;

  assign qp = {2'b00, quality_knob[15:2]};
  assign vp = {2'b00, variation_knob[15:2]};

  assign quality_next = quantize(qp, QualityThr, 3'd5, hyst.quality, last_quality);
  assign var_mm  = quantize(vp, VarMajMinThr, 3'd3, hyst.variation,
                            {1'b0, last_variation_major_minor});
  assign var_da  = quantize(vp, VarDimAugThr, 3'd2, hyst.variation,
                            {1'b0, last_variation_dim_aug});
  assign var_sus = quantize(vp, VarSusThr, 3'd1, hyst.variation,
                            {2'b00, last_variation_sus});
  assign voicing_next = quantize(voicing_knob, VoicingThr, 3'd7, hyst.voicing,
                                 last_voicing);

  // the new quality picks which variation memory is used
  always_comb begin
    case (quality_next)
      QUAL_MAJ, QUAL_MIN: variation_sel = var_mm[1:0];
      QUAL_DIM, QUAL_AUG: variation_sel = var_da[1:0];
      QUAL_SUS:           variation_sel = var_sus[1:0];
      default:            variation_sel = 2'd0;
    endcase
  end

  assign codes.quality   = quality_next;
  assign codes.variation = variation_sel;
  assign codes.voicing   = voicing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_quality               <= '0;
      last_variation_major_minor <= '0;
      last_variation_dim_aug     <= '0;
      last_variation_sus         <= 1'b0;
      last_voicing               <= '0;
    end else if (load) begin
      last_quality <= quality_next;
      last_voicing <= voicing_next;
      case (quality_next)
        QUAL_MAJ, QUAL_MIN: last_variation_major_minor <= var_mm[1:0];
        QUAL_DIM, QUAL_AUG: last_variation_dim_aug     <= var_da[1:0];
        QUAL_SUS:           last_variation_sus         <= var_sus[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/cvg_voicing.sv
// ----------------------------------------------------------------------------
// cvg_voicing
// Chord table lookup and octave moves of root and intervals per voicing.
// ----------------------------------------------------------------------------
module cvg_voicing (
  input  logic signed [15:0] root_pitch,
  input  cvg_pkg::codes_t    codes,
  output logic signed [16:0] pitch,
  output logic signed [13:0] iv0,
  output logic signed [13:0] iv1,
  output logic signed [13:0] iv2
);
  import cvg_pkg::*;

  localparam logic signed [16:0] PitchOct = 17'sd1536;
  localparam logic signed [13:0] Oct      = 14'sd1536;
  localparam logic signed [13:0] TwoOct   = 14'sd3072;

  semis_t             semis;
  logic signed [16:0] root_ext;
  logic signed [13:0] base0;
  logic signed [13:0] base1;
  logic signed [13:0] base2;

  assign semis    = chord_semis(codes.quality, codes.variation);
  assign root_ext = {root_pitch[15], root_pitch};
  assign base0    = {3'b000, semis[0], 7'b0};
  assign base1    = {3'b000, semis[1], 7'b0};
  assign base2    = {3'b000, semis[2], 7'b0};

  always_comb begin
    pitch = root_ext;
    iv0   = base0;
    iv1   = base1;
    iv2   = base2;
    unique case (codes.voicing)
      VOIC_ROOT: ;
      VOIC_FIRST: begin
        pitch = root_ext + PitchOct;
        iv0   = base0 - Oct;
        iv1   = base1 - Oct;
        iv2   = base2 - Oct;
      end
      VOIC_SECOND: begin
        pitch = root_ext + PitchOct;
        iv1   = base1 - Oct;
        iv2   = base2 - Oct;
      end
      VOIC_THIRD: begin
        pitch = root_ext + PitchOct;
        iv2   = base2 - Oct;
      end
      VOIC_DROP2: iv1 = base1 - Oct;
      VOIC_DROP3: iv0 = base0 - Oct;
      VOIC_SPREAD: begin
        pitch = root_ext - PitchOct;
        iv0   = base0 + Oct;
        iv1   = base1 + Oct;
        iv2   = base2 + TwoOct;
      end
      VOIC_SPREAD2: begin
        pitch = root_ext - PitchOct;
        iv1   = base1 + Oct;
        iv2   = base2 + TwoOct;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/chord_voicing_generator_core.sv
// ----------------------------------------------------------------------------
// chord_voicing_generator_core
// Knob-driven chord generator: quantizes quality, variation and voicing knobs
// with hysteresis and emits a voiced root pitch and three chord intervals.
// ----------------------------------------------------------------------------
// Each accepted word lands in an input register; the quantizers, chord table
// and octave adders then settle combinationally and the result is loaded into
// the output register once that register is free, so one word is taken per
// clock while the output is not stalled. A result passes the input and output
// registers and is taken at an edge where out_ready is high. The hysteresis
// memories update as a word moves to the output register. Hysteresis
// registers are written through wr_en/wr_index/wr_data (low nine bits used) and
// should only change while no word is in flight.
module chord_voicing_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [cvg_pkg::HystWidth-1:0] wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            root_pitch_in,
  input  logic [15:0]                   quality_knob,
  input  logic [15:0]                   variation_knob,
  input  logic [15:0]                   voicing_knob,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [16:0]            root_pitch_out,
  output logic signed [13:0]            first_interval,
  output logic signed [13:0]            second_interval,
  output logic signed [13:0]            third_interval
);
  import cvg_pkg::*;

  hyst_t hyst;

  logic               stage_valid;
  logic signed [15:0] stage_root;
  logic [15:0]        stage_quality;
  logic [15:0]        stage_variation;
  logic [15:0]        stage_voicing;

  logic               advance;
  codes_t             codes;
  logic signed [16:0] pitch;
  logic signed [13:0] iv0;
  logic signed [13:0] iv1;
  logic signed [13:0] iv2;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst.quality   <= HystReset;
      hyst.variation <= HystReset;
      hyst.voicing   <= HystReset;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_QUALITY_HYST:   hyst.quality   <= wr_data;
        REG_VARIATION_HYST: hyst.variation <= wr_data;
        REG_VOICING_HYST:   hyst.voicing   <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_root      <= root_pitch_in;
      stage_quality   <= quality_knob;
      stage_variation <= variation_knob;
      stage_voicing   <= voicing_knob;
    end
  end

  cvg_quantizer_bank u_quant (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .quality_knob   (stage_quality),
    .variation_knob (stage_variation),
    .voicing_knob   (stage_voicing),
    .hyst           (hyst),
    .codes          (codes)
  );

  cvg_voicing u_voicing (
    .root_pitch (stage_root),
    .codes      (codes),
    .pitch      (pitch),
    .iv0        (iv0),
    .iv1        (iv1),
    .iv2        (iv2)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      root_pitch_out  <= pitch;
      first_interval  <= iv0;
      second_interval <= iv1;
      third_interval  <= iv2;
    end
  end

endmodule

// File: tb/tb_chord_voicing_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chord_voicing_generator_core
// Self-checking bench: a chord predictor tracks the hysteresis memories and
// builds the expected voiced chord for every accepted word. Directed chords
// come first, then random phases under several hysteresis settings, with
// bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_chord_voicing_generator_core;
  import cvg_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int Semitone = 128;
  localparam int Octave   = 12 * Semitone;

  typedef struct packed {
    logic [16:0] root_pitch;
    logic [13:0] first;
    logic [13:0] second;
    logic [13:0] third;
  } chord_t;

  class chord_scoreboard;
    int          h_quality;
    int          h_variation;
    int          h_voicing;
    logic [2:0]  prev_quality;
    logic [1:0]  prev_var_maj_min;
    logic [1:0]  prev_var_dim_aug;
    logic        prev_var_sus;
    logic [2:0]  prev_voicing;
    chord_t      chord_q[$];
    int          errors;

    function new();
      h_quality        = int'(HystReset);
      h_variation      = int'(HystReset);
      h_voicing        = int'(HystReset);
      prev_quality     = '0;
      prev_var_maj_min = '0;
      prev_var_dim_aug = '0;
      prev_var_sus     = 1'b0;
      prev_voicing     = '0;
      errors           = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [8:0] val);
      case (idx)
        REG_QUALITY_HYST:   h_quality = int'(val);
        REG_VARIATION_HYST: h_variation = int'(val);
        REG_VOICING_HYST:   h_voicing = int'(val);
        default: ;
      endcase
    endfunction

    function int pending();
      return chord_q.size();
    endfunction

    // thresholds are evenly spaced: step * 1 .. step * n, highest tested first
    function int band_code(input int p, input int step, input int n, input int h,
                           input int prev);
      int thr;
      for (int i = n - 1; i >= 0; i--) begin
        thr = step * (i + 1);
        if (p > thr + h) return i + 1;
        if (p > thr - h) return prev;
      end
      return 0;
    endfunction

    function void chord_tones(input logic [2:0] q, input logic [1:0] v,
                              output int t0, output int t1, output int t2);
      t0 = 4;
      t1 = 7;
      t2 = 12;
      case (q)
        QUAL_MAJ: begin
          case (v)
            2'd1: t2 = 11;
            2'd2: t2 = 9;
            2'd3: begin
              t1 = 6;
              t2 = 10;
            end
            default: ;
          endcase
        end
        QUAL_MIN: begin
          t0 = 3;
          case (v)
            2'd1: t2 = 10;
            2'd2: t2 = 9;
            2'd3: t2 = 11;
            default: ;
          endcase
        end
        QUAL_DOM: t2 = 10;
        QUAL_DIM: begin
          t0 = 3;
          t1 = 6;
          case (v)
            2'd0: ;
            2'd1: t2 = 9;
            default: t2 = 10;
          endcase
        end
        QUAL_SUS: t0 = (v == 2'd0) ? 2 : 5;
        QUAL_AUG: begin
          case (v)
            2'd0: t1 = 8;
            2'd1: begin
              t1 = 8;
              t2 = 10;
            end
            default: t2 = 9;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void note_word(input logic [15:0] root, input logic [15:0] q_knob,
                            input logic [15:0] v_knob, input logic [15:0] c_knob);
      logic [2:0] qual;
      logic [1:0] vari;
      logic [2:0] voic;
      int         t0, t1, t2;
      int         pitch, iv0, iv1, iv2;
      chord_t     e;
      qual = 3'(band_code(int'(q_knob >> 2), 820, 5, h_quality, int'(prev_quality)));
      prev_quality = qual;
      vari = '0;
      case (qual)
        QUAL_MAJ, QUAL_MIN: begin
          vari = 2'(band_code(int'(v_knob >> 2), 1024, 3, h_variation,
                              int'(prev_var_maj_min)));
          prev_var_maj_min = vari;
        end
        QUAL_DIM, QUAL_AUG: begin
          vari = 2'(band_code(int'(v_knob >> 2), 1365, 2, h_variation,
                              int'(prev_var_dim_aug)));
          prev_var_dim_aug = vari;
        end
        QUAL_SUS: begin
          vari = 2'(band_code(int'(v_knob >> 2), 2048, 1, h_variation,
                              int'(prev_var_sus)));
          prev_var_sus = vari[0];
        end
        default: ;  // dominant leaves every variation memory alone
      endcase
      voic = 3'(band_code(int'(c_knob), 512, 7, h_voicing, int'(prev_voicing)));
      prev_voicing = voic;

      chord_tones(qual, vari, t0, t1, t2);
      iv0 = t0 * Semitone;
      iv1 = t1 * Semitone;
      iv2 = t2 * Semitone;
      pitch = int'($signed(root));
      case (voic)
        VOIC_FIRST: begin
          pitch += Octave;
          iv0 -= Octave;
          iv1 -= Octave;
          iv2 -= Octave;
        end
        VOIC_SECOND: begin
          pitch += Octave;
          iv1 -= Octave;
          iv2 -= Octave;
        end
        VOIC_THIRD: begin
          pitch += Octave;
          iv2 -= Octave;
        end
        VOIC_DROP2: iv1 -= Octave;
        VOIC_DROP3: iv0 -= Octave;
        VOIC_SPREAD: begin
          pitch -= Octave;
          iv0 += Octave;
          iv1 += Octave;
          iv2 += 2 * Octave;
        end
        VOIC_SPREAD2: begin
          pitch -= Octave;
          iv1 += Octave;
          iv2 += 2 * Octave;
        end
        default: ;
      endcase
      e.root_pitch = 17'(pitch);
      e.first      = 14'(iv0);
      e.second     = 14'(iv1);
      e.third      = 14'(iv2);
      chord_q.push_back(e);
    endfunction

    function void cmp_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(input logic [16:0] pitch, input logic [13:0] a,
                             input logic [13:0] b, input logic [13:0] c);
      chord_t e;
      if (chord_q.size() == 0) begin
        $error("output word with no expected chord");
        errors++;
        return;
      end
      e = chord_q.pop_front();
      cmp_field("root_pitch_out", int'($signed(e.root_pitch)), int'($signed(pitch)));
      cmp_field("first_interval", int'($signed(e.first)), int'($signed(a)));
      cmp_field("second_interval", int'($signed(e.second)), int'($signed(b)));
      cmp_field("third_interval", int'($signed(e.third)), int'($signed(c)));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [1:0]           wr_index = REG_QUALITY_HYST;
  logic [HystWidth-1:0] wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   root_pitch_in = '0;
  logic [15:0]          quality_knob = '0;
  logic [15:0]          variation_knob = '0;
  logic [15:0]          voicing_knob = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [16:0]   root_pitch_out;
  logic signed [13:0]   first_interval;
  logic signed [13:0]   second_interval;
  logic signed [13:0]   third_interval;

  chord_scoreboard sb = new();
  int              burst_left = 0;
  int              stall_cnt = 0;
  logic [1:0]      stall_mode = 2'd0;

  chord_voicing_generator_core dut (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .root_pitch_in   (root_pitch_in),
    .quality_knob    (quality_knob),
    .variation_knob  (variation_knob),
    .voicing_knob    (voicing_knob),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .root_pitch_out  (root_pitch_out),
    .first_interval  (first_interval),
    .second_interval (second_interval),
    .third_interval  (third_interval)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output stalls: the stall mode is redrawn whenever its counter runs out
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_cnt  <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= stall_cnt[2];
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(root_pitch_out, first_interval, second_interval, third_interval);
  end

  task automatic send_word(input logic [15:0] r, input logic [15:0] q,
                           input logic [15:0] v, input logic [15:0] c);
    in_valid       <= 1'b1;
    root_pitch_in  <= r;
    quality_knob   <= q;
    variation_knob <= v;
    voicing_knob   <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(r, q, v, c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [8:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_hyst(input logic [8:0] hq, input logic [8:0] hv,
                          input logic [8:0] hc);
    drain();
    repeat (4) @(posedge clk);
    write_one(REG_QUALITY_HYST, hq);
    write_one(REG_VARIATION_HYST, hv);
    write_one(REG_VOICING_HYST, hc);
    write_one(REG_UNUSED, 9'($urandom));  // must not disturb anything
    wr_en <= 1'b0;
  endtask

  // mostly aims at the dead bands of the current setting
  function automatic logic [15:0] pick_knob(input int step, input int n, input int h,
                                            input bit shifted);
    int p;
    int sel;
    sel = int'($urandom_range(0, 9));
    if (sel < 3) return 16'($urandom);
    if (sel == 3) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    p = step * int'($urandom_range(1, n)) + int'($urandom_range(0, 2 * h + 80)) - (h + 40);
    if (shifted) p = p * 4 + int'($urandom_range(0, 3));
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return 16'(p);
  endfunction

  task automatic random_word();
    logic [15:0] r;
    logic [15:0] v;
    if ($urandom_range(0, 9) == 0)
      r = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
    else
      r = 16'($urandom);
    if ($urandom_range(0, 1) != 0)
      v = pick_knob(1024, 3, sb.h_variation, 1'b1);
    else
      v = pick_knob(1365, 2, sb.h_variation, 1'b1);
    send_word(r, pick_knob(820, 5, sb.h_quality, 1'b1), v,
              pick_knob(512, 7, sb.h_voicing, 1'b0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every quality, variation and voicing
    send_word(16'h8000, 16'd0, 16'd0, 16'd0);
    send_word(16'h7fff, 16'hffff, 16'hffff, 16'hffff);
    send_word(16'd0, 16'd4800, 16'd14000, 16'd600);
    send_word(16'd1000, 16'd4800, 16'd6000, 16'd1100);  // minor seventh
    send_word(16'hfc00, 16'd4800, 16'd400, 16'd1700);
    send_word(16'd7, 16'd4800, 16'd10000, 16'd2200);
    send_word(16'd300, 16'd400, 16'd14000, 16'd2700);
    send_word(16'd300, 16'd400, 16'd6000, 16'd3200);
    send_word(16'd300, 16'd400, 16'd10000, 16'd3900);
    send_word(16'd0, 16'd8000, 16'd0, 16'd0);            // dominant
    send_word(16'd0, 16'd11600, 16'd8000, 16'd0);
    send_word(16'd0, 16'd11600, 16'd12000, 16'd0);
    send_word(16'd0, 16'd11600, 16'd400, 16'd0);
    send_word(16'd0, 16'd14800, 16'd400, 16'd0);
    send_word(16'd0, 16'd14800, 16'd12000, 16'd0);
    send_word(16'd0, 16'd20000, 16'd8000, 16'd0);
    send_word(16'd0, 16'd20000, 16'd400, 16'd0);
    // dead bands keep the previous codes
    send_word(16'd0, 16'd16200, 16'd5660, 16'd612);
    // back to major: its own variation memory still holds
    send_word(16'd0, 16'd400, 16'd8192, 16'd0);
    send_word(16'd0, 16'd8000, 16'd40000, 16'd0);       // dominant, memories untouched
    send_word(16'd0, 16'd400, 16'd4096, 16'd0);
    // overlapping dead bands
    set_hyst(9'd511, 9'd511, 9'd511);
    send_word(16'd0, 16'd0, 16'd0, 16'd1024);
    send_word(16'h8000, 16'hffff, 16'hffff, 16'hffff);
    send_word(16'd0, 16'd9840, 16'd8192, 16'd2048);
    set_hyst(9'd0, 9'd0, 9'd0);
    send_word(16'd0, 16'd3284, 16'd4100, 16'd513);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_hyst(9'd0, 9'd0, 9'd0);
        1: set_hyst(9'd511, 9'd511, 9'd511);
        2: set_hyst(HystReset, HystReset, HystReset);
        default: set_hyst(9'($urandom), 9'($urandom), 9'($urandom));
      endcase
      for (int i = 0; i < 92; i++) begin
        if (i == 46) drain();
        random_word();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
